[rtl/srd_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// srd_pkg: shared types and constants for the refraction direction block
// Fixed-point formats, payload types and the index settings bundle.
// ============================================================================
package srd_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DIR_W     = 18;
  localparam int IDX_W     = 15;
  localparam int ETA_FRAC  = 24;
  localparam int ETA_W     = IDX_W + 12;
  localparam int EINV_W    = ETA_FRAC + 1;
  localparam int E2DIR_W   = 2 * IDX_W;
  localparam int E2_W      = E2DIR_W + 1;

  localparam logic [IDX_W-1:0] IDX_ONE   = IDX_W'(4096);
  localparam logic [IDX_W-1:0] IDX_RESET = IDX_W'(6144);

  typedef logic signed [DIR_W-1:0] dir_t;
  typedef logic [IDX_W-1:0]        idx_t;

  typedef struct packed {
    logic               busy;
    logic [IDX_W-1:0]   n;
    logic [EINV_W-1:0]  eta_inv;
    logic [EINV_W-1:0]  e2_inv;
    logic [E2DIR_W-1:0] e2_dir;
  } eta_cfg_t;

endpackage

[rtl/srd_if.sv]
`timescale 1ns / 1ps
// ============================================================================
// srd_if: valid/ready channels of the refraction direction block
// Input channel carries one direction, output channel one refracted result.
// ============================================================================
interface srd_in_if;
  logic          valid;
  logic          ready;
  srd_pkg::dir_t dir_x;
  srd_pkg::dir_t dir_y;
  srd_pkg::dir_t dir_z;
  modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
  modport sink   (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

interface srd_out_if;
  logic          valid;
  logic          ready;
  logic          refracted;
  srd_pkg::dir_t out_x;
  srd_pkg::dir_t out_y;
  srd_pkg::dir_t out_z;
  modport source (output valid, output refracted, output out_x, output out_y, output out_z,
                  input ready);
  modport sink   (input valid, input refracted, input out_x, input out_y, input out_z,
                  output ready);
endinterface

[rtl/srd_cfg.sv]
`timescale 1ns / 1ps
// ============================================================================
// srd_cfg: index register and derived ratio constants
// Holds the clamped index, derives 1/n and its square by a bit-serial divider
// followed by a shift-add multiplier, and n squared by a direct product.
// ============================================================================
module srd_cfg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  srd_pkg::idx_t    cfg_wdata,
  output srd_pkg::eta_cfg_t cfg_o
);
  import srd_pkg::*;

  localparam int NUM_W    = 37;
  localparam int REM_W    = IDX_W + 1;
  localparam int ACC_W    = 2 * EINV_W;
  localparam int CNT_W    = 6;

  typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_DIV, ST_MUL} state_t;

  state_t              state_r;
  logic [IDX_W-1:0]    n_r;
  logic [NUM_W-1:0]    num_r;
  logic [REM_W-1:0]    rem_r;
  logic [EINV_W-1:0]   quo_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [ACC_W-1:0]    mc_r;
  logic [EINV_W-1:0]   mp_r;
  logic [ACC_W-1:0]    acc_r;
  logic [E2DIR_W-1:0]  e2dir_r;

  logic [REM_W:0]      rem_sh;
  logic                take;
  logic [REM_W-1:0]    rem_nxt;
  logic [EINV_W-1:0]   quo_nxt;
  logic [ACC_W-1:0]    acc_round;

  always_comb begin
    rem_sh  = {rem_r, num_r[NUM_W-1]};
    take    = rem_sh >= {2'b00, n_r};
    rem_nxt = take ? REM_W'(rem_sh - {2'b00, n_r}) : rem_sh[REM_W-1:0];
    quo_nxt = {quo_r[EINV_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      n_r     <= IDX_RESET;
    end else if (cfg_we) begin
      n_r     <= (cfg_wdata < IDX_ONE) ? IDX_ONE : cfg_wdata;
      state_r <= ST_LOAD;
    end else begin
      case (state_r)
        ST_LOAD: begin
          num_r   <= {1'b1, 22'd0, n_r[IDX_W-1:1]};
          rem_r   <= '0;
          quo_r   <= '0;
          cnt_r   <= CNT_W'(NUM_W - 1);
          e2dir_r <= n_r * n_r;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          rem_r <= rem_nxt;
          quo_r <= quo_nxt;
          num_r <= num_r << 1;
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            mc_r    <= ACC_W'(quo_nxt);
            mp_r    <= quo_nxt;
            acc_r   <= '0;
            cnt_r   <= CNT_W'(EINV_W - 1);
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (mp_r[0]) begin
            acc_r <= acc_r + mc_r;
          end
          mc_r  <= mc_r << 1;
          mp_r  <= mp_r >> 1;
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign acc_round = (acc_r + (ACC_W'(1) << (ETA_FRAC - 1))) >> ETA_FRAC;

  always_comb begin
    cfg_o.busy    = state_r != ST_IDLE;
    cfg_o.n       = n_r;
    cfg_o.eta_inv = quo_r;
    cfg_o.e2_inv  = acc_round[EINV_W-1:0];
    cfg_o.e2_dir  = e2dir_r;
  end

endmodule

[rtl/srd_sqrt.sv]
`timescale 1ns / 1ps
// ============================================================================
// srd_sqrt: pipelined integer square root
// One result bit per stage, floor of the root, with a side payload and a
// valid bit that travel alongside.
// ============================================================================
module srd_sqrt #(
  parameter int RW = 20,
  parameter int PW = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            vld_in,
  input  logic [2*RW-1:0] rad_in,
  input  logic [PW-1:0]   pay_in,
  output logic            vld_out,
  output logic [RW-1:0]   root_out,
  output logic [PW-1:0]   pay_out
);

  logic [RW+1:0]   rem_r  [RW];
  logic [RW-1:0]   root_r [RW];
  logic [2*RW-1:0] rad_r  [RW];
  logic [PW-1:0]   pay_r  [RW];
  logic            vld_r  [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [RW+1:0]   rem_i;
    logic [RW-1:0]   root_i;
    logic [2*RW-1:0] rad_i;
    logic [PW-1:0]   pay_i;
    logic            vld_i;
    logic [RW+1:0]   rem_sh;
    logic [RW+1:0]   trial;

    if (k == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign rad_i  = rad_in;
      assign pay_i  = pay_in;
      assign vld_i  = vld_in;
    end else begin : g_next
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
      assign rad_i  = rad_r[k-1];
      assign pay_i  = pay_r[k-1];
      assign vld_i  = vld_r[k-1];
    end

    assign rem_sh = {rem_i[RW-1:0], rad_i[2*RW-1 -: 2]};
    assign trial  = {root_i, 2'b01};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_sh >= trial) begin
          rem_r[k]  <= rem_sh - trial;
          root_r[k] <= {root_i[RW-2:0], 1'b1};
        end else begin
          rem_r[k]  <= rem_sh;
          root_r[k] <= {root_i[RW-2:0], 1'b0};
        end
        rad_r[k] <= rad_i << 2;
        pay_r[k] <= pay_i;
      end
    end
  end

  assign vld_out  = vld_r[RW-1];
  assign root_out = root_r[RW-1];
  assign pay_out  = pay_r[RW-1];

endmodule

[rtl/snell_refraction_direction.sv]
`timescale 1ns / 1ps
// ============================================================================
// snell_refraction_direction: Snell refraction with total internal reflection
// Refracts a local-frame direction through the configured index and returns
// the normalized refracted direction, or a reflection flag.
// ============================================================================
//
//  Channel   Direction  Handshake        Payload
//  in_ch     in         valid / ready    dir_x, dir_y, dir_z
//  out_ch    out        valid / ready    refracted, out_x, out_y, out_z
//  cfg       in         cfg_we           cfg_wdata (refractive index, Q3.12)
//
//  One item is accepted per cycle while in_ch.ready is high; each result
//  passes five front stages, two square-root pipelines of 20 and 21 stages,
//  two stages between them, one setup stage, a 17-stage divider and the
//  output register. After reset and after each index write the ratio unit
//  runs one load step, 37 divide steps and 25 multiply steps with in_ch.ready
//  low. A stalled output freezes the whole pipeline; the first stage still
//  takes an item while it is empty.
//
module snell_refraction_direction (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  srd_pkg::idx_t cfg_wdata,
  srd_in_if.sink        in_ch,
  srd_out_if.source     out_ch
);
  import srd_pkg::*;

  localparam int ONE    = 1 << FRAC_BITS;
  localparam int VW     = 21;
  localparam int PX_W   = ETA_W + DIR_W + 1;
  localparam int S_W    = 20;
  localparam int P4_W   = 50;
  localparam int W_W    = 26;
  localparam int RW1    = 20;
  localparam int RW2    = 21;
  localparam int SQ_W   = 2 * RW1 + 1;
  localparam int LEN_W  = RW2;
  localparam int QW     = FRAC_BITS + 1;
  localparam int NUM_W  = 38;

  typedef struct packed {
    logic signed [VW-1:0] vx;
    logic signed [VW-1:0] vy;
    logic                 zpos;
    logic                 zneg;
    logic                 tir;
  } sq1_pay_t;

  typedef struct packed {
    logic signed [VW-1:0] vx;
    logic signed [VW-1:0] vy;
    logic signed [VW-1:0] vz;
    logic                 tir;
  } sq2_pay_t;

  function automatic logic signed [VW-1:0] neg_rnd_eta(input logic signed [PX_W-1:0] p);
    logic [PX_W-1:0] mag;
    logic [PX_W-1:0] sh;
    mag = p[PX_W-1] ? $unsigned(-p) : $unsigned(p);
    sh  = (mag + (PX_W'(1) << (ETA_FRAC - 1))) >> ETA_FRAC;
    return p[PX_W-1] ? $signed(sh[VW-1:0]) : -$signed(sh[VW-1:0]);
  endfunction

  function automatic logic signed [W_W-1:0] rnd_e2(input logic signed [P4_W-1:0] p);
    logic [P4_W-1:0] mag;
    logic [P4_W-1:0] sh;
    mag = p[P4_W-1] ? $unsigned(-p) : $unsigned(p);
    sh  = (mag + (P4_W'(1) << (ETA_FRAC - 1))) >> ETA_FRAC;
    return p[P4_W-1] ? -$signed(sh[W_W-1:0]) : $signed(sh[W_W-1:0]);
  endfunction

  eta_cfg_t cfg_s;
  logic     en;
  logic     en1;

  srd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg_s)
  );

  logic vo_r;
  logic v1_r;

  assign en          = !(vo_r && !out_ch.ready);
  assign en1         = en || !v1_r;
  assign in_ch.ready = en1 && !cfg_s.busy;

  // Stage 1: capture and ratio selection
  dir_t                 x1_r, y1_r, z1_r;
  logic [ETA_W-1:0]     eta1_r;
  logic [E2_W-1:0]      e21_r;
  logic                 zpos1_r, zneg1_r;
  logic                 zpos_in;

  assign zpos_in = !in_ch.dir_z[DIR_W-1] && (in_ch.dir_z != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_ch.valid && in_ch.ready;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      x1_r    <= in_ch.dir_x;
      y1_r    <= in_ch.dir_y;
      z1_r    <= in_ch.dir_z;
      zpos1_r <= zpos_in;
      zneg1_r <= in_ch.dir_z[DIR_W-1];
      eta1_r  <= zpos_in ? ETA_W'(cfg_s.eta_inv) : {cfg_s.n, 12'd0};
      e21_r   <= zpos_in ? E2_W'(cfg_s.e2_inv) : E2_W'(cfg_s.e2_dir);
    end
  end

  // Stage 2: products
  logic                    v2_r;
  logic signed [2*DIR_W-1:0] zz2_r;
  logic signed [PX_W-1:0]  px2_r, py2_r;
  logic [E2_W-1:0]         e22_r;
  logic                    zpos2_r, zneg2_r;
  logic signed [2*DIR_W-1:0] zz2_nxt;
  logic signed [PX_W-1:0]  px2_nxt, py2_nxt;

  always_comb begin
    zz2_nxt = z1_r * z1_r;
    px2_nxt = $signed({1'b0, eta1_r}) * x1_r;
    py2_nxt = $signed({1'b0, eta1_r}) * y1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zz2_r   <= zz2_nxt;
      px2_r   <= px2_nxt;
      py2_r   <= py2_nxt;
      e22_r   <= e21_r;
      zpos2_r <= zpos1_r;
      zneg2_r <= zneg1_r;
    end
  end

  // Stage 3: rounding of the products
  logic                 v3_r;
  logic signed [S_W-1:0] s3_r;
  logic signed [VW-1:0] vx3_r, vy3_r;
  logic [E2_W-1:0]      e23_r;
  logic                 zpos3_r, zneg3_r;
  logic [2*DIR_W-1:0]   zr_full;
  logic signed [S_W-1:0] s3_nxt;

  always_comb begin
    zr_full = ($unsigned(zz2_r) + (2*DIR_W)'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    s3_nxt  = $signed(S_W'(ONE)) - $signed({1'b0, zr_full[S_W-2:0]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r    <= s3_nxt;
      vx3_r   <= neg_rnd_eta(px2_r);
      vy3_r   <= neg_rnd_eta(py2_r);
      e23_r   <= e22_r;
      zpos3_r <= zpos2_r;
      zneg3_r <= zneg2_r;
    end
  end

  // Stage 4: eta^2 times (1 - z^2)
  logic                  v4_r;
  logic signed [P4_W-1:0] p4_r;
  logic signed [VW-1:0]  vx4_r, vy4_r;
  logic                  zpos4_r, zneg4_r;
  logic signed [P4_W-1:0] p4_nxt;

  assign p4_nxt = $signed({1'b0, e23_r}) * s3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p4_r    <= p4_nxt;
      vx4_r   <= vx3_r;
      vy4_r   <= vy3_r;
      zpos4_r <= zpos3_r;
      zneg4_r <= zneg3_r;
    end
  end

  // Stage 5: squared cosine and reflection test
  logic                  v5_r;
  logic [RW1+3:0]        w5_r;
  logic                  tir5_r;
  logic signed [VW-1:0]  vx5_r, vy5_r;
  logic                  zpos5_r, zneg5_r;
  logic signed [W_W-1:0] w5_nxt;

  assign w5_nxt = $signed(W_W'(ONE)) - rnd_e2(p4_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tir5_r  <= w5_nxt[W_W-1];
      w5_r    <= w5_nxt[W_W-1] ? '0 : w5_nxt[RW1+3:0];
      vx5_r   <= vx4_r;
      vy5_r   <= vy4_r;
      zpos5_r <= zpos4_r;
      zneg5_r <= zneg4_r;
    end
  end

  // Root of the squared cosine
  sq1_pay_t           pay1_in, pay1_out;
  logic               va;
  logic [RW1-1:0]     root_a;

  always_comb begin
    pay1_in.vx   = vx5_r;
    pay1_in.vy   = vy5_r;
    pay1_in.zpos = zpos5_r;
    pay1_in.zneg = zneg5_r;
    pay1_in.tir  = tir5_r;
  end

  srd_sqrt #(
    .RW (RW1),
    .PW ($bits(sq1_pay_t))
  ) u_sqrt_cos (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .vld_in   (v5_r),
    .rad_in   ({w5_r, {FRAC_BITS{1'b0}}}),
    .pay_in   (pay1_in),
    .vld_out  (va),
    .root_out (root_a),
    .pay_out  (pay1_out)
  );

  // Stage Q: z component and squares
  logic                 vq_r;
  logic signed [VW-1:0] vxq_r, vyq_r, vzq_r;
  logic [SQ_W-1:0]      sqx_r, sqy_r, sqz_r;
  logic                 tirq_r;
  logic signed [VW-1:0] vz_nxt;
  logic signed [2*VW-1:0] sqx_nxt, sqy_nxt, sqz_nxt;

  always_comb begin
    if (pay1_out.zpos) begin
      vz_nxt = -$signed({1'b0, root_a});
    end else if (pay1_out.zneg) begin
      vz_nxt = $signed({1'b0, root_a});
    end else begin
      vz_nxt = '0;
    end
    sqx_nxt = pay1_out.vx * pay1_out.vx;
    sqy_nxt = pay1_out.vy * pay1_out.vy;
    sqz_nxt = vz_nxt * vz_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vq_r <= 1'b0;
    end else if (en) begin
      vq_r <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vxq_r  <= pay1_out.vx;
      vyq_r  <= pay1_out.vy;
      vzq_r  <= vz_nxt;
      sqx_r  <= sqx_nxt[SQ_W-1:0];
      sqy_r  <= sqy_nxt[SQ_W-1:0];
      sqz_r  <= sqz_nxt[SQ_W-1:0];
      tirq_r <= pay1_out.tir;
    end
  end

  // Stage S: squared length
  logic                 vs_r;
  logic [2*RW2-1:0]     sum_s_r;
  sq2_pay_t             pay2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vs_r <= 1'b0;
    end else if (en) begin
      vs_r <= vq_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_s_r    <= (2*RW2)'(sqx_r) + (2*RW2)'(sqy_r) + (2*RW2)'(sqz_r);
      pay2_r.vx  <= vxq_r;
      pay2_r.vy  <= vyq_r;
      pay2_r.vz  <= vzq_r;
      pay2_r.tir <= tirq_r;
    end
  end

  // Length root
  sq2_pay_t           pay2_out;
  logic               vb;
  logic [RW2-1:0]     root_b;

  srd_sqrt #(
    .RW (RW2),
    .PW ($bits(sq2_pay_t))
  ) u_sqrt_len (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .vld_in   (vs_r),
    .rad_in   (sum_s_r),
    .pay_in   (pay2_r),
    .vld_out  (vb),
    .root_out (root_b),
    .pay_out  (pay2_out)
  );

  // Stage N: divider setup
  logic                 nv_r;
  logic [NUM_W-1:0]     nrem_r [3];
  logic [LEN_W-1:0]     nlen_r;
  logic [2:0]           nneg_r;
  logic                 ntir_r, nzero_r;
  logic signed [VW-1:0] comp_b [3];

  assign comp_b[0] = pay2_out.vx;
  assign comp_b[1] = pay2_out.vy;
  assign comp_b[2] = pay2_out.vz;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nv_r <= 1'b0;
    end else if (en) begin
      nv_r <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        nrem_r[l] <= ({17'd0, (comp_b[l][VW-1] ? $unsigned(-comp_b[l])
                                               : $unsigned(comp_b[l]))} << FRAC_BITS)
                     + {18'd0, root_b[LEN_W-1:1]};
        nneg_r[l] <= comp_b[l][VW-1];
      end
      nlen_r  <= root_b;
      ntir_r  <= pay2_out.tir;
      nzero_r <= root_b == '0;
    end
  end

  // Restoring divider, one quotient bit per stage, three lanes
  logic [NUM_W-1:0] drem_r [QW][3];
  logic [QW-1:0]    dq_r   [QW][3];
  logic [LEN_W-1:0] dlen_r [QW];
  logic [2:0]       dneg_r [QW];
  logic             dtir_r [QW];
  logic             dzero_r[QW];
  logic             dv_r   [QW];

  for (genvar k = 0; k < QW; k++) begin : g_div
    localparam int SH = QW - 1 - k;
    logic [NUM_W-1:0] rem_i [3];
    logic [QW-1:0]    q_i   [3];
    logic [LEN_W-1:0] len_i;
    logic [2:0]       neg_i;
    logic             tir_i, zero_i, v_i;
    logic [NUM_W-1:0] sub;

    if (k == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < 3; l++) begin
          rem_i[l] = nrem_r[l];
          q_i[l]   = '0;
        end
      end
      assign len_i  = nlen_r;
      assign neg_i  = nneg_r;
      assign tir_i  = ntir_r;
      assign zero_i = nzero_r;
      assign v_i    = nv_r;
    end else begin : g_next
      always_comb begin
        for (int l = 0; l < 3; l++) begin
          rem_i[l] = drem_r[k-1][l];
          q_i[l]   = dq_r[k-1][l];
        end
      end
      assign len_i  = dlen_r[k-1];
      assign neg_i  = dneg_r[k-1];
      assign tir_i  = dtir_r[k-1];
      assign zero_i = dzero_r[k-1];
      assign v_i    = dv_r[k-1];
    end

    assign sub = NUM_W'(len_i) << SH;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k] <= 1'b0;
      end else if (en) begin
        dv_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 3; l++) begin
          if (rem_i[l] >= sub) begin
            drem_r[k][l] <= rem_i[l] - sub;
            dq_r[k][l]   <= {q_i[l][QW-2:0], 1'b1};
          end else begin
            drem_r[k][l] <= rem_i[l];
            dq_r[k][l]   <= {q_i[l][QW-2:0], 1'b0};
          end
        end
        dlen_r[k]  <= len_i;
        dneg_r[k]  <= neg_i;
        dtir_r[k]  <= tir_i;
        dzero_r[k] <= zero_i;
      end
    end
  end

  // Output register
  logic refr_r;
  dir_t ox_r, oy_r, oz_r;
  dir_t o_nxt [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (dtir_r[QW-1] || dzero_r[QW-1]) begin
        o_nxt[l] = '0;
      end else if (dneg_r[QW-1][l]) begin
        o_nxt[l] = -$signed({1'b0, dq_r[QW-1][l]});
      end else begin
        o_nxt[l] = $signed({1'b0, dq_r[QW-1][l]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en) begin
      vo_r <= dv_r[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      refr_r <= !dtir_r[QW-1];
      ox_r   <= o_nxt[0];
      oy_r   <= o_nxt[1];
      oz_r   <= o_nxt[2];
    end
  end

  assign out_ch.valid     = vo_r;
  assign out_ch.refracted = refr_r;
  assign out_ch.out_x     = ox_r;
  assign out_ch.out_y     = oy_r;
  assign out_ch.out_z     = oz_r;

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |-> !cfg_s.busy)
    else $error("item accepted while the ratio unit is busy");

  a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> cfg_s.busy)
    else $error("index write did not start the ratio unit");

  a_tir_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.refracted) |->
      (out_ch.out_x == '0 && out_ch.out_y == '0 && out_ch.out_z == '0))
    else $error("reflected item carries a nonzero direction");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.out_x <= $signed(DIR_W'(ONE)) &&
                      out_ch.out_x >= -$signed(DIR_W'(ONE)) &&
                      out_ch.out_z <= $signed(DIR_W'(ONE)) &&
                      out_ch.out_z >= -$signed(DIR_W'(ONE))))
    else $error("normalized component outside unit range");

  a_stall_keep: assert property (@(posedge clk) disable iff (!rst_n)
    (vo_r && !out_ch.ready) |=> vo_r)
    else $error("stalled result dropped");
`endif

endmodule

[sim/snell_refraction_direction_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// snell_refraction_direction_tb: testbench of the refraction direction block
// Drives directions in bursts through the input channel under several index
// settings, stalls the output, and checks each result against known rows or a
// fixed-point model of Snell refraction with total internal reflection.
// ============================================================================
module snell_refraction_direction_tb;
  import srd_pkg::*;

  typedef struct packed {
    logic refracted;
    dir_t x;
    dir_t y;
    dir_t z;
  } refr_t;

  typedef struct {
    dir_t  x;
    dir_t  y;
    dir_t  z;
    logic  known;
    refr_t res;
  } dir_row_t;

  localparam int LATENCY    = 67;
  localparam int WATCHDOG   = 5000;
  localparam int N_RANDOM   = 800;
  localparam logic [DIR_W-1:0] DMAX = 18'h1ffff;
  localparam logic [DIR_W-1:0] DMIN = 18'h20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  idx_t cfg_wdata = IDX_RESET;
  idx_t index_model = IDX_RESET;

  srd_in_if  in_ch ();
  srd_out_if out_ch ();

  snell_refraction_direction i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source)
  );

  always #1 clk = ~clk;

  refr_t   refractions_due[$];
  int      mismatches = 0;
  int      idle_cycles = 0;
  bit      hold_long = 1'b0;
  bit      done = 1'b0;

  function automatic logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint rshift_away(longint v, int k);
    longint half;
    half = longint'(1) << (k - 1);
    if (v >= 0) return (v + half) >>> k;
    return -((-v + half) >>> k);
  endfunction

  function automatic dir_t unit_component(longint v, longint len);
    longint mag;
    longint q;
    mag = (v < 0) ? -v : v;
    q = ((mag <<< FRAC_BITS) + (len >>> 1)) / len;
    if (v < 0) q = -q;
    if (q > 131071) q = 131071;
    if (q < -131072) q = -131072;
    return dir_t'(q);
  endfunction

  function automatic refr_t refract(dir_t dx, dir_t dy, dir_t dz, idx_t idx);
    longint one;
    longint x, y, z, n, eta, e2, s, w, r, vx, vy, vz, len;
    refr_t o;
    one = longint'(1) << FRAC_BITS;
    x = dx;
    y = dy;
    z = dz;
    n = idx;
    o = '0;
    if (n < 4096) n = 4096;
    if (z > 0) eta = ((longint'(1) << 36) + (n >>> 1)) / n;
    else eta = n <<< 12;
    e2 = (eta * eta + (longint'(1) << (ETA_FRAC - 1))) >>> ETA_FRAC;
    s = one - rshift_away(z * z, FRAC_BITS);
    w = one - rshift_away(e2 * s, ETA_FRAC);
    if (w < 0) return o;
    r = longint'(isqrt(64'(w) << FRAC_BITS));
    vx = -rshift_away(eta * x, ETA_FRAC);
    vy = -rshift_away(eta * y, ETA_FRAC);
    vz = (z > 0) ? -r : ((z < 0) ? r : 0);
    len = longint'(isqrt(64'(vx * vx + vy * vy + vz * vz)));
    o.refracted = 1'b1;
    if (len == 0) return o;
    o.x = unit_component(vx, len);
    o.y = unit_component(vy, len);
    o.z = unit_component(vz, len);
    return o;
  endfunction

  task automatic send_direction(dir_t dx, dir_t dy, dir_t dz, logic known, refr_t res);
    in_ch.valid <= 1'b1;
    in_ch.dir_x <= dx;
    in_ch.dir_y <= dy;
    in_ch.dir_z <= dz;
    do @(posedge clk); while (!in_ch.ready);
    refractions_due.push_back(known ? res : refract(dx, dy, dz, index_model));
  endtask

  task automatic offer_gap();
    if ($urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic dir_t rand_dir();
    case ($urandom_range(0, 5))
      0: return dir_t'($urandom);
      1: return DMAX;
      2: return DMIN;
      default: return dir_t'($signed($urandom_range(0, 131072)) - 65536);
    endcase
  endfunction

  task automatic set_index(idx_t v);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (refractions_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    index_model = v;
  endtask

  task automatic random_phase(int count);
    dir_t dx, dy, dz;
    int burst;
    int k;
    k = 0;
    while (k < count) begin
      burst = $urandom_range(1, 20);
      repeat (burst) begin
        dx = rand_dir();
        dy = rand_dir();
        dz = rand_dir();
        send_direction(dx, dy, dz, 1'b0, '0);
        k++;
      end
      offer_gap();
    end
  endtask

  initial begin
    dir_row_t rows[$];
    idx_t settings[6];
    int p;
    in_ch.valid = 1'b0;
    in_ch.dir_x = '0;
    in_ch.dir_y = '0;
    in_ch.dir_z = '0;
    rows = '{
      '{18'sd0, 18'sd0, 18'sd65536, 1'b1, refr_t'{1'b1, 18'sd0, 18'sd0, -18'sd65536}},
      '{18'sd0, 18'sd0, -18'sd65536, 1'b1, refr_t'{1'b1, 18'sd0, 18'sd0, 18'sd65536}},
      '{18'sd65536, 18'sd0, 18'sd0, 1'b1, refr_t'{1'b0, 18'sd0, 18'sd0, 18'sd0}},
      '{18'sd0, 18'sd0, 18'sd0, 1'b0, '0},
      '{18'sd46341, 18'sd0, 18'sd46341, 1'b0, '0},
      '{18'sd46341, 18'sd0, -18'sd46341, 1'b0, '0},
      '{DMAX, DMAX, DMAX, 1'b0, '0},
      '{DMIN, DMIN, DMIN, 1'b0, '0},
      '{DMIN, DMAX, 18'sd1, 1'b0, '0},
      '{18'sd10000, -18'sd20000, 18'sd60000, 1'b0, '0},
      '{-18'sd10000, 18'sd20000, -18'sd60000, 1'b0, '0},
      '{18'sd0, 18'sd65536, -18'sd1, 1'b0, '0},
      '{18'sd131071, 18'sd0, 18'sd100000, 1'b0, '0},
      '{-18'sd1, -18'sd1, 18'sd0, 1'b0, '0}
    };
    settings = '{IDX_W'(4096), IDX_W'(0), IDX_W'(32767), IDX_W'(4095), IDX_W'(5461),
                 IDX_W'(12000)};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    foreach (rows[i]) send_direction(rows[i].x, rows[i].y, rows[i].z, rows[i].known,
                                     rows[i].res);
    random_phase(100);
    hold_long = 1'b1;
    random_phase(100);
    hold_long = 1'b0;
    foreach (settings[s]) begin
      set_index(settings[s]);
      for (p = 3; p < rows.size(); p++)
        send_direction(rows[p].x, rows[p].y, rows[p].z, 1'b0, '0);
      random_phase(N_RANDOM / 8);
    end
    in_ch.valid <= 1'b0;
    done = 1'b1;
  end

  initial begin
    int phase;
    int n;
    bit held;
    out_ch.ready = 1'b0;
    phase = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_long && !held) begin
        out_ch.ready <= 1'b0;
        n = 0;
        while (n < 200) begin
          @(posedge clk);
          n++;
        end
        held = 1'b1;
      end
      phase++;
      if ((phase / 64) % 3 == 0) out_ch.ready <= 1'b1;
      else out_ch.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    refr_t got;
    refr_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.refracted, out_ch.out_x, out_ch.out_y, out_ch.out_z};
      if (refractions_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = refractions_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: want r=%b x=%0d y=%0d z=%0d, got r=%b x=%0d y=%0d z=%0d",
                     want.refracted, want.x, want.y, want.z,
                     got.refracted, got.x, got.y, got.z);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || refractions_due.size() == 0)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (done);
    while (refractions_due.size() != 0 && idle_cycles < WATCHDOG) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (refractions_due.size() == 0 && mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
